>>> rtl/core/tbf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Tape block framer package
// Shared widths, tape word constants, register indexes and the
// ones'-complement adder used for block checksums.
// ----------------------------------------------------------------------------
package tbf_pkg;

  localparam int WORD_W   = 18;
  localparam int ADDR_W   = 16;
  localparam int LOADER_W = 12;
  localparam int CFG_IDX_W = 2;

  typedef logic [WORD_W-1:0]   word_t;
  typedef logic [ADDR_W-1:0]   addr_t;
  typedef logic [LOADER_W-1:0] loader_t;

  // Input opcodes.
  localparam logic OP_DATA = 1'b0;
  localparam logic OP_END  = 1'b1;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_MODE     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_EXTENDED_MODE  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_LOADER_ADDRESS = 2'd2;

  // Tape words.
  localparam word_t BLOCK_MARK = 18'o330000;
  localparam word_t DEPOSIT_OP = 18'o320000;
  localparam word_t JUMP_OP    = 18'o600000;
  localparam word_t EXT_JUMP   = 18'o610000;

  // Reset value of the loader area base.
  localparam loader_t LOADER_RESET = 12'd4070;

  // 18-bit ones'-complement add with end-around carry.
  function automatic word_t oc_add(word_t a, word_t b);
    logic [WORD_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[WORD_W-1:0] + WORD_W'(s[WORD_W]);
  endfunction

endpackage

>>> rtl/core/tbf_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Tape block framer channels
// Valid/ready channels for the input items and the punched tape words.
// ----------------------------------------------------------------------------
interface tbf_in_if;
  logic                      valid;
  logic                      ready;
  logic                      opcode;
  logic [tbf_pkg::ADDR_W-1:0] address;
  logic [tbf_pkg::WORD_W-1:0] data_word;

  modport source (output valid, output opcode, output address, output data_word,
                  input ready);
  modport sink (input valid, input opcode, input address, input data_word,
                output ready);
endinterface

interface tbf_out_if;
  logic                      valid;
  logic                      ready;
  logic [tbf_pkg::WORD_W-1:0] tape_word;
  logic                      last;
  logic                      error;

  modport source (output valid, output tape_word, output last, output error,
                  input ready);
  modport sink (input valid, input tape_word, input last, input error,
                output ready);
endinterface

>>> rtl/core/tbf_buffer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Tape block framer word buffer
// Single-port-write, single-port-read memory with a registered read.
// ----------------------------------------------------------------------------
module tbf_buffer #(
  parameter int DEPTH = 32,
  parameter int IDX_W = 5
) (
  input  logic                       clk_i,
  input  logic                       we_i,
  input  logic [IDX_W-1:0]           waddr_i,
  input  logic [tbf_pkg::WORD_W-1:0] wdata_i,
  input  logic [IDX_W-1:0]           raddr_i,
  output logic [tbf_pkg::WORD_W-1:0] rdata_o
);
  import tbf_pkg::*;

  word_t mem [DEPTH];
  word_t rdata_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // Registered read port.
  always_ff @(posedge clk_i) begin
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

>>> rtl/core/tape_block_framer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Tape block framer
// Frames 18-bit words for a paper-tape block loader.
// ----------------------------------------------------------------------------
// Usage:
//   in_i carries one item per beat: a data word with its address, or an end
//   item with the start address. out_o carries the tape words in punch order;
//   last marks the final beat caused by an item, error marks a loader-area hit.
//   Configuration is written through cfg_we_i/cfg_idx_i/cfg_data_i while idle.
// Throughput and sequencing:
//   A data word that is only buffered is accepted, then stored. A direct-mode
//   pair gives an address and a data beat, a loader error one error beat.
//   A flush of N buffered words gives mark, start and end address beats, the
//   words and a checksum beat, one word per cycle while the output is not
//   held, paced by the single read port of the word buffer; the memory read
//   address is steered from the next pointer so the read latency is hidden.
//   The end item adds one or two jump beats. One item is worked on at a time;
//   the next is taken once its last beat, if any, is in the output register.
// Reset:
//   The buffer is empty, block and extended mode are on, and the loader area
//   starts at 4070. The buffer memory itself is not cleared.
// Stalls:
//   A held output beat stays in the output register; the framer waits and
//   loses nothing.
// ----------------------------------------------------------------------------
module tape_block_framer #(
  parameter int BLOCK_WORDS = 32
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  tbf_in_if.sink                        in_i,
  tbf_out_if.source                     out_o,
  input  logic                          cfg_we_i,
  input  logic [tbf_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [tbf_pkg::LOADER_W-1:0]  cfg_data_i
);
  import tbf_pkg::*;

  localparam int CNT_W = $clog2(BLOCK_WORDS + 1);
  localparam int IDX_W = (BLOCK_WORDS > 1) ? $clog2(BLOCK_WORDS) : 1;
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(BLOCK_WORDS);
  localparam logic [CNT_W-1:0] CNT_ONE  = CNT_W'(1);

  typedef enum logic [3:0] {
    ST_IDLE, ST_DECIDE, ST_ERR, ST_PAIR_A, ST_PAIR_D, ST_MARK, ST_START,
    ST_ENDA, ST_WORD, ST_CSUM, ST_JUMP, ST_JADDR
  } state_e;

  state_e           state_q, state_d;
  logic             op_q, op_d;
  addr_t            addr_q, addr_d;
  word_t            data_q, data_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  addr_t            start_q, start_d;
  word_t            sum_q, sum_d;
  logic [IDX_W-1:0] ptr_q, ptr_d;
  logic             out_valid_q, out_valid_d;
  word_t            tape_q, tape_d;
  logic             last_q, last_d;
  logic             err_q, err_d;
  logic             block_mode_q, ext_mode_q;
  loader_t          loader_q;

  logic             mem_we;
  logic [IDX_W-1:0] mem_waddr;
  word_t            rd_data;

  logic             slot_free;
  logic [ADDR_W:0]  end_sum;
  word_t            end_word;
  logic             loader_hit;
  logic             need_flush;
  logic             last_word;

  tbf_buffer #(
    .DEPTH (BLOCK_WORDS),
    .IDX_W (IDX_W)
  ) u_buffer (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (data_q),
    .raddr_i (ptr_d),
    .rdata_o (rd_data)
  );

  // Block end address and the tests made on a new data word.
  assign end_sum    = {1'b0, start_q} + (ADDR_W + 1)'(cnt_q);
  assign end_word   = WORD_W'(end_sum);
  assign loader_hit = (addr_q[ADDR_W-1:LOADER_W] == '0) &&
                      (addr_q[LOADER_W-1:0] >= loader_q);
  assign need_flush = (cnt_q >= CNT_FULL) || (cnt_q == '0) ||
                      ({1'b0, addr_q} != end_sum);
  assign last_word  = (CNT_W'(ptr_q) + CNT_ONE) == cnt_q;

  assign slot_free = !out_valid_q || out_o.ready;

  // Sequencer: walks one item through its tape beats.
  always_comb begin
    state_d     = state_q;
    op_d        = op_q;
    addr_d      = addr_q;
    data_d      = data_q;
    cnt_d       = cnt_q;
    start_d     = start_q;
    sum_d       = sum_q;
    ptr_d       = '0;
    out_valid_d = out_valid_q && !out_o.ready;
    tape_d      = tape_q;
    last_d      = last_q;
    err_d       = err_q;
    mem_we      = 1'b0;
    mem_waddr   = cnt_q[IDX_W-1:0];

    case (state_q)
      ST_IDLE: begin
        if (in_i.valid) begin
          op_d    = in_i.opcode;
          addr_d  = in_i.address;
          data_d  = in_i.data_word;
          state_d = ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        if (op_q == OP_END) begin
          state_d = (cnt_q != '0) ? ST_MARK : ST_JUMP;
        end else if (block_mode_q) begin
          if (loader_hit) begin
            state_d = ST_ERR;
          end else if (need_flush && cnt_q != '0) begin
            state_d = ST_MARK;
          end else begin
            // The word continues the block, or opens an empty one.
            if (need_flush) begin
              start_d = addr_q;
            end
            mem_we  = 1'b1;
            cnt_d   = cnt_q + CNT_ONE;
            state_d = ST_IDLE;
          end
        end else begin
          state_d = ST_PAIR_A;
        end
      end
      ST_ERR: begin
        if (slot_free) begin
          out_valid_d = 1'b1;
          tape_d      = '0;
          last_d      = 1'b1;
          err_d       = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      ST_PAIR_A: begin
        if (slot_free) begin
          out_valid_d = 1'b1;
          tape_d      = {{(WORD_W - ADDR_W){1'b0}}, addr_q} | DEPOSIT_OP;
          last_d      = 1'b0;
          err_d       = 1'b0;
          state_d     = ST_PAIR_D;
        end
      end
      ST_PAIR_D: begin
        if (slot_free) begin
          out_valid_d = 1'b1;
          tape_d      = data_q;
          last_d      = 1'b1;
          err_d       = 1'b0;
          state_d     = ST_IDLE;
        end
      end
      ST_MARK: begin
        if (slot_free) begin
          out_valid_d = 1'b1;
          tape_d      = BLOCK_MARK;
          last_d      = 1'b0;
          err_d       = 1'b0;
          state_d     = ST_START;
        end
      end
      ST_START: begin
        if (slot_free) begin
          out_valid_d = 1'b1;
          tape_d      = {{(WORD_W - ADDR_W){1'b0}}, start_q};
          last_d      = 1'b0;
          err_d       = 1'b0;
          sum_d       = {{(WORD_W - ADDR_W){1'b0}}, start_q};
          state_d     = ST_START == state_q ? ST_ENDA : state_q;
        end
      end
      ST_ENDA: begin
        if (slot_free) begin
          out_valid_d = 1'b1;
          tape_d      = end_word;
          last_d      = 1'b0;
          err_d       = 1'b0;
          sum_d       = oc_add(sum_q, end_word);
          state_d     = ST_WORD;
        end
      end
      ST_WORD: begin
        // The read address follows the next pointer, so rd_data always
        // holds the entry at ptr_q.
        ptr_d = ptr_q;
        if (slot_free) begin
          out_valid_d = 1'b1;
          tape_d      = rd_data;
          last_d      = 1'b0;
          err_d       = 1'b0;
          sum_d       = oc_add(sum_q, rd_data);
          if (last_word) begin
            state_d = ST_CSUM;
          end else begin
            ptr_d = ptr_q + IDX_W'(1);
          end
        end
      end
      ST_CSUM: begin
        if (slot_free) begin
          out_valid_d = 1'b1;
          tape_d      = sum_q;
          last_d      = (op_q == OP_DATA);
          err_d       = 1'b0;
          cnt_d       = '0;
          if (op_q == OP_END) begin
            state_d = ST_JUMP;
          end else begin
            // The breaking word opens the next block.
            start_d   = addr_q;
            mem_we    = 1'b1;
            mem_waddr = '0;
            cnt_d     = CNT_ONE;
            state_d   = ST_IDLE;
          end
        end
      end
      ST_JUMP: begin
        if (slot_free) begin
          out_valid_d = 1'b1;
          err_d       = 1'b0;
          if (ext_mode_q) begin
            tape_d  = EXT_JUMP;
            last_d  = 1'b0;
            state_d = ST_JADDR;
          end else begin
            tape_d  = {{(WORD_W - ADDR_W){1'b0}}, addr_q} | JUMP_OP;
            last_d  = 1'b1;
            state_d = ST_IDLE;
          end
        end
      end
      ST_JADDR: begin
        if (slot_free) begin
          out_valid_d = 1'b1;
          tape_d      = {{(WORD_W - ADDR_W){1'b0}}, addr_q};
          last_d      = 1'b1;
          err_d       = 1'b0;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // State, registered outputs and configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      op_q         <= OP_DATA;
      addr_q       <= '0;
      data_q       <= '0;
      cnt_q        <= '0;
      start_q      <= '0;
      sum_q        <= '0;
      ptr_q        <= '0;
      out_valid_q  <= 1'b0;
      tape_q       <= '0;
      last_q       <= 1'b0;
      err_q        <= 1'b0;
      block_mode_q <= 1'b1;
      ext_mode_q   <= 1'b1;
      loader_q     <= LOADER_RESET;
    end else begin
      state_q     <= state_d;
      op_q        <= op_d;
      addr_q      <= addr_d;
      data_q      <= data_d;
      cnt_q       <= cnt_d;
      start_q     <= start_d;
      sum_q       <= sum_d;
      ptr_q       <= ptr_d;
      out_valid_q <= out_valid_d;
      tape_q      <= tape_d;
      last_q      <= last_d;
      err_q       <= err_d;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_BLOCK_MODE:     block_mode_q <= cfg_data_i[0];
          CFG_EXTENDED_MODE:  ext_mode_q   <= cfg_data_i[0];
          CFG_LOADER_ADDRESS: loader_q     <= cfg_data_i;
          default: begin
          end
        endcase
      end
    end
  end

  assign in_i.ready      = (state_q == ST_IDLE);
  assign out_o.valid     = out_valid_q;
  assign out_o.tape_word = tape_q;
  assign out_o.last      = last_q;
  assign out_o.error     = err_q;

`ifndef SYNTHESIS
  // The buffer never holds more than a block.
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_FULL)
    else $error("block count exceeds the buffer depth");

  // Words are only read out below the fill count.
  a_ptr_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_WORD) |-> (CNT_W'(ptr_q) < cnt_q))
    else $error("buffer read beyond the fill count");

  // An error beat is always a lone zero word.
  a_err_beat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.error) |-> (out_o.last && out_o.tape_word == '0))
    else $error("error beat is not a lone zero word");

  // An accepted item is worked on before the next one is taken.
  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_i.valid && in_i.ready) |=> !in_i.ready)
    else $error("second item taken while one is at work");
`endif

endmodule
